@@ sv/vchm_pkg.sv @@
// shared types and constants of the voxel column height map
`default_nettype none

package vchm_pkg;

   localparam int VOXEL_W     = 8;
   localparam int SIZE_X_W    = 7;
   localparam int SIZE_Y_W    = 13;
   localparam int SIZE_Z_W    = 7;
   localparam int AIR_W       = 8;
   localparam int BSIZE_W     = 7;
   localparam int HEIGHT_W    = 13;
   localparam int HALF_W      = 16;
   localparam int WORD_W      = 32;
   localparam int INDEX_W     = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [SIZE_X_W-1:0] SIZE_X_RESET = 7'd32;
   localparam logic [SIZE_Y_W-1:0] SIZE_Y_RESET = 13'd128;
   localparam logic [SIZE_Z_W-1:0] SIZE_Z_RESET = 7'd32;
   localparam logic [AIR_W-1:0]    AIR_RESET    = 8'd0;
   localparam logic [BSIZE_W-1:0]  BSIZE_RESET  = 7'd8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SIZE_X     = 3'd0,
      REG_SIZE_Y     = 3'd1,
      REG_SIZE_Z     = 3'd2,
      REG_AIR_CODE   = 3'd3,
      REG_BLOCK_SIZE = 3'd4
   } csr_reg_type;

   typedef enum logic {
      KIND_HEIGHT = 1'b0,
      KIND_BLOCK  = 1'b1
   } kind_type;

   typedef struct packed {
      logic accept_voxel;
      logic col_step;
      logic h_flush;
      logic blk_step;
      logic b_flush;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic slice_end;
      logic col_last;
      logic blk_last;
      logic chunk_end;
      logic row_end;
      logic can_emit;
   } status_type;

endpackage

`default_nettype wire

@@ sv/vchm_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module vchm_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ sv/vchm_ctrl.sv @@
// sequencer for voxel intake, slice sweep, block row sweep and flushes
`default_nettype none

module vchm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      csr_ready,
   input  wire vchm_pkg::status_type status,
   output vchm_pkg::cmd_type         cmd
);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_COL_RD  = 8'b0000_0010,
      ST_COL_WR  = 8'b0000_0100,
      ST_H_FLUSH = 8'b0000_1000,
      ST_BLK_RD  = 8'b0001_0000,
      ST_BLK_WR  = 8'b0010_0000,
      ST_B_FLUSH = 8'b0100_0000,
      ST_FINISH  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept_voxel = 1'b1;
               if (status.slice_end) begin
                  state_in = ST_COL_RD;
               end
            end
         end
         ST_COL_RD: begin
            state_in = ST_COL_WR;
         end
         ST_COL_WR: begin
            if (status.can_emit) begin
               cmd.col_step = 1'b1;
               if (!status.col_last) begin
                  state_in = ST_COL_RD;
               end else if (status.chunk_end) begin
                  state_in = ST_H_FLUSH;
               end else if (status.row_end) begin
                  state_in = ST_BLK_RD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_H_FLUSH: begin
            if (status.can_emit) begin
               cmd.h_flush = 1'b1;
               state_in    = ST_BLK_RD;
            end
         end
         ST_BLK_RD: begin
            state_in = ST_BLK_WR;
         end
         ST_BLK_WR: begin
            if (status.can_emit) begin
               cmd.blk_step = 1'b1;
               if (!status.blk_last) begin
                  state_in = ST_BLK_RD;
               end else if (status.chunk_end) begin
                  state_in = ST_B_FLUSH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_B_FLUSH: begin
            if (status.can_emit) begin
               cmd.b_flush = 1'b1;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.can_emit) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/vchm_dp.sv @@
// datapath: config registers, position counters, column and block stores, word packing
`default_nettype none

module vchm_dp #(
   parameter int MAX_SIZE_X = 64,
   parameter int MAX_SIZE_Y = 4096,
   parameter int MAX_SIZE_Z = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [vchm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [vchm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic [vchm_pkg::VOXEL_W-1:0]        voxel_type,
   input  wire vchm_pkg::cmd_type                   cmd,
   output vchm_pkg::status_type                     status,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_valid,
   output logic                                     rsp_kind,
   output logic [vchm_pkg::INDEX_W-1:0]             rsp_word_index,
   output logic [vchm_pkg::WORD_W-1:0]              rsp_packed_word,
   output logic                                     rsp_last
);

   localparam int AW  = $clog2(MAX_SIZE_X);
   localparam int YW  = $clog2(MAX_SIZE_Y);
   localparam int ZW  = $clog2(MAX_SIZE_Z + 1);
   localparam int XSW = $clog2(MAX_SIZE_X + 1);
   localparam int YSW = $clog2(MAX_SIZE_Y + 1);
   localparam int ZSW = $clog2(MAX_SIZE_Z + 1);
   localparam int HW  = vchm_pkg::HEIGHT_W;
   localparam int PAD = vchm_pkg::HALF_W - vchm_pkg::HEIGHT_W;
   localparam int BW  = vchm_pkg::BSIZE_W;
   localparam int IW  = vchm_pkg::INDEX_W;

   // configuration
   logic [vchm_pkg::SIZE_X_W-1:0] size_x_ff, size_x_in;
   logic [vchm_pkg::SIZE_Y_W-1:0] size_y_ff, size_y_in;
   logic [vchm_pkg::SIZE_Z_W-1:0] size_z_ff, size_z_in;
   logic [vchm_pkg::AIR_W-1:0]    air_ff, air_in;
   logic [BW-1:0]                 bsize_ff, bsize_in;
   logic                          restart;

   logic [XSW-1:0] sx;
   logic [YSW-1:0] sy;
   logic [ZSW-1:0] sz;
   logic [BW-1:0]  b;

   // position and sweep state
   logic [AW-1:0]  pos_x_ff, pos_x_in;
   logic [YW-1:0]  pos_y_ff, pos_y_in;
   logic [ZW-1:0]  pos_z_ff, pos_z_in;
   logic [BW-1:0]  zb_ff, zb_in;
   logic [AW-1:0]  sw_x_ff, sw_x_in;
   logic [BW-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]  bx_ff, bx_in;
   logic [AW-1:0]  base_ff, base_in;

   logic [MAX_SIZE_X-1:0] col_valid_ff, col_valid_in;
   logic [MAX_SIZE_X-1:0] blk_valid_ff, blk_valid_in;

   logic [HW-1:0] h_pend_ff, h_pend_in;
   logic          h_pend_v_ff, h_pend_v_in;
   logic [HW-1:0] b_pend_ff, b_pend_in;
   logic          b_pend_v_ff, b_pend_v_in;
   logic [IW-1:0] h_cnt_ff, h_cnt_in;
   logic [IW-1:0] b_cnt_ff, b_cnt_in;

   // result staging: hold stage then output register
   logic                            hold_v_ff, hold_v_in;
   logic                            hold_kind_ff, hold_kind_in;
   logic [IW-1:0]                   hold_idx_ff, hold_idx_in;
   logic [vchm_pkg::WORD_W-1:0]     hold_word_ff, hold_word_in;
   logic                            out_v_ff, out_v_in;
   logic                            out_kind_ff, out_kind_in;
   logic [IW-1:0]                   out_idx_ff, out_idx_in;
   logic [vchm_pkg::WORD_W-1:0]     out_word_ff, out_word_in;
   logic                            out_last_ff, out_last_in;

   // stores
   logic          col_we;
   logic [HW-1:0] col_wdata, col_rdata;
   logic          blk_we;
   logic [HW-1:0] blk_wdata, blk_rdata;

   logic [31:0]   y_next;
   logic [HW-1:0] h_val, bm_val, blk_val;
   logic          x_more, y_more, chunk_end, row_end, col_last, blk_last;
   logic          out_free, can_emit, emit, move;
   logic          emit_kind;
   logic [IW-1:0] emit_idx;
   logic [vchm_pkg::WORD_W-1:0] emit_word;

   // size clamping
   always_comb begin
      if (size_x_ff == '0) begin
         sx = XSW'(1);
      end else if (32'(size_x_ff) > 32'(MAX_SIZE_X)) begin
         sx = XSW'(MAX_SIZE_X);
      end else begin
         sx = XSW'(size_x_ff);
      end
      if (size_y_ff == '0) begin
         sy = YSW'(1);
      end else if (32'(size_y_ff) > 32'(MAX_SIZE_Y)) begin
         sy = YSW'(MAX_SIZE_Y);
      end else begin
         sy = YSW'(size_y_ff);
      end
      if (size_z_ff == '0) begin
         sz = ZSW'(1);
      end else if (32'(size_z_ff) > 32'(MAX_SIZE_Z)) begin
         sz = ZSW'(MAX_SIZE_Z);
      end else begin
         sz = ZSW'(size_z_ff);
      end
      b = (bsize_ff == '0) ? BW'(1) : bsize_ff;
   end

   assign x_more    = (32'(pos_x_ff) + 32'd1) < 32'(sx);
   assign y_more    = (32'(pos_y_ff) + 32'd1) < 32'(sy);
   assign chunk_end = (32'(pos_z_ff) + 32'd1) >= 32'(sz);
   assign row_end   = chunk_end || (zb_ff == b - BW'(1));
   assign col_last  = (32'(sw_x_ff) + 32'd1) >= 32'(sx);
   assign blk_last  = (32'(base_ff) + 32'(b)) >= 32'(sx);

   assign out_free = !out_v_ff || !rsp_stall;
   assign can_emit = !hold_v_ff || out_free;

   always_comb begin
      status.slice_end = !x_more && !y_more;
      status.col_last  = col_last;
      status.blk_last  = blk_last;
      status.chunk_end = chunk_end;
      status.row_end   = row_end;
      status.can_emit  = can_emit;
   end

   // column store: written by voxels, read during the slice sweep
   assign y_next    = 32'(pos_y_ff) + 32'd1;
   assign col_wdata = y_next[HW-1:0];
   assign col_we    = cmd.accept_voxel && (voxel_type != air_ff);

   vchm_ram #(
      .WIDTH (HW),
      .DEPTH (MAX_SIZE_X)
   ) u_col_ram (
      .clock (clock),
      .we    (col_we),
      .waddr (pos_x_ff),
      .wdata (col_wdata),
      .raddr (sw_x_ff),
      .rdata (col_rdata)
   );

   // block store: running maxima of the current block row
   assign h_val     = col_valid_ff[sw_x_ff] ? col_rdata : '0;
   assign bm_val    = blk_valid_ff[bx_ff] ? blk_rdata : '0;
   assign blk_val   = bm_val;
   assign blk_we    = cmd.col_step;
   assign blk_wdata = (h_val > bm_val) ? h_val : bm_val;

   vchm_ram #(
      .WIDTH (HW),
      .DEPTH (MAX_SIZE_X)
   ) u_blk_ram (
      .clock (clock),
      .we    (blk_we),
      .waddr (bx_ff),
      .wdata (blk_wdata),
      .raddr (bx_ff),
      .rdata (blk_rdata)
   );

   // config writes
   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      air_in    = air_ff;
      bsize_in  = bsize_ff;
      restart   = 1'b0;
      if (csr_we) begin
         unique case (vchm_pkg::csr_reg_type'(csr_index))
            vchm_pkg::REG_SIZE_X: begin
               size_x_in = csr_wdata[vchm_pkg::SIZE_X_W-1:0];
               restart   = 1'b1;
            end
            vchm_pkg::REG_SIZE_Y: begin
               size_y_in = csr_wdata[vchm_pkg::SIZE_Y_W-1:0];
               restart   = 1'b1;
            end
            vchm_pkg::REG_SIZE_Z: begin
               size_z_in = csr_wdata[vchm_pkg::SIZE_Z_W-1:0];
               restart   = 1'b1;
            end
            vchm_pkg::REG_AIR_CODE: begin
               air_in = csr_wdata[vchm_pkg::AIR_W-1:0];
            end
            vchm_pkg::REG_BLOCK_SIZE: begin
               bsize_in = csr_wdata[BW-1:0];
               restart  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // position, sweep counters, pending halves and packing
   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      zb_in        = zb_ff;
      sw_x_in      = sw_x_ff;
      cnt_in       = cnt_ff;
      bx_in        = bx_ff;
      base_in      = base_ff;
      col_valid_in = col_valid_ff;
      blk_valid_in = blk_valid_ff;
      h_pend_in    = h_pend_ff;
      h_pend_v_in  = h_pend_v_ff;
      b_pend_in    = b_pend_ff;
      b_pend_v_in  = b_pend_v_ff;
      h_cnt_in     = h_cnt_ff;
      b_cnt_in     = b_cnt_ff;
      emit         = 1'b0;
      emit_kind    = vchm_pkg::KIND_HEIGHT;
      emit_idx     = h_cnt_ff;
      emit_word    = '0;

      if (cmd.accept_voxel) begin
         if (col_we) begin
            col_valid_in[pos_x_ff] = 1'b1;
         end
         if (x_more) begin
            pos_x_in = pos_x_ff + AW'(1);
         end else begin
            pos_x_in = '0;
            pos_y_in = y_more ? pos_y_ff + YW'(1) : '0;
         end
      end

      if (cmd.col_step) begin
         col_valid_in[sw_x_ff] = 1'b0;
         blk_valid_in[bx_ff]   = 1'b1;
         if (h_pend_v_ff) begin
            emit        = 1'b1;
            emit_word   = {{PAD{1'b0}}, h_val, {PAD{1'b0}}, h_pend_ff};
            h_cnt_in    = h_cnt_ff + IW'(1);
            h_pend_v_in = 1'b0;
         end else begin
            h_pend_in   = h_val;
            h_pend_v_in = 1'b1;
         end
         if (col_last) begin
            sw_x_in = '0;
            cnt_in  = '0;
            bx_in   = '0;
            base_in = '0;
         end else begin
            sw_x_in = sw_x_ff + AW'(1);
            if (cnt_ff == b - BW'(1)) begin
               cnt_in = '0;
               bx_in  = bx_ff + AW'(1);
            end else begin
               cnt_in = cnt_ff + BW'(1);
            end
         end
      end

      if (cmd.h_flush && h_pend_v_ff) begin
         emit        = 1'b1;
         emit_word   = {{vchm_pkg::HALF_W{1'b0}}, {PAD{1'b0}}, h_pend_ff};
         h_cnt_in    = h_cnt_ff + IW'(1);
         h_pend_v_in = 1'b0;
      end

      if (cmd.blk_step) begin
         blk_valid_in[bx_ff] = 1'b0;
         emit_kind = vchm_pkg::KIND_BLOCK;
         emit_idx  = b_cnt_ff;
         if (b_pend_v_ff) begin
            emit        = 1'b1;
            emit_word   = {{PAD{1'b0}}, blk_val, {PAD{1'b0}}, b_pend_ff};
            b_cnt_in    = b_cnt_ff + IW'(1);
            b_pend_v_in = 1'b0;
         end else begin
            b_pend_in   = blk_val;
            b_pend_v_in = 1'b1;
         end
         if (blk_last) begin
            bx_in   = '0;
            base_in = '0;
         end else begin
            bx_in   = bx_ff + AW'(1);
            base_in = AW'(32'(base_ff) + 32'(b));
         end
      end

      if (cmd.b_flush && b_pend_v_ff) begin
         emit        = 1'b1;
         emit_kind   = vchm_pkg::KIND_BLOCK;
         emit_idx    = b_cnt_ff;
         emit_word   = {{vchm_pkg::HALF_W{1'b0}}, {PAD{1'b0}}, b_pend_ff};
         b_cnt_in    = b_cnt_ff + IW'(1);
         b_pend_v_in = 1'b0;
      end

      if (cmd.finish) begin
         if (chunk_end) begin
            pos_z_in = '0;
            zb_in    = '0;
            h_cnt_in = '0;
            b_cnt_in = '0;
         end else begin
            pos_z_in = pos_z_ff + ZW'(1);
            zb_in    = row_end ? '0 : zb_ff + BW'(1);
         end
      end

      if (restart) begin
         pos_x_in     = '0;
         pos_y_in     = '0;
         pos_z_in     = '0;
         zb_in        = '0;
         sw_x_in      = '0;
         cnt_in       = '0;
         bx_in        = '0;
         base_in      = '0;
         col_valid_in = '0;
         blk_valid_in = '0;
         h_pend_v_in  = 1'b0;
         b_pend_v_in  = 1'b0;
         h_cnt_in     = '0;
         b_cnt_in     = '0;
      end
   end

   // hold the newest beat back until it is known whether it is the final one
   assign move = hold_v_ff && (emit || cmd.finish);

   always_comb begin
      hold_v_in    = hold_v_ff;
      hold_kind_in = hold_kind_ff;
      hold_idx_in  = hold_idx_ff;
      hold_word_in = hold_word_ff;
      out_v_in     = out_v_ff;
      out_kind_in  = out_kind_ff;
      out_idx_in   = out_idx_ff;
      out_word_in  = out_word_ff;
      out_last_in  = out_last_ff;
      if (out_v_ff && !rsp_stall) begin
         out_v_in = 1'b0;
      end
      if (move) begin
         out_v_in    = 1'b1;
         out_kind_in = hold_kind_ff;
         out_idx_in  = hold_idx_ff;
         out_word_in = hold_word_ff;
         out_last_in = cmd.finish;
      end
      if (emit) begin
         hold_v_in    = 1'b1;
         hold_kind_in = emit_kind;
         hold_idx_in  = emit_idx;
         hold_word_in = emit_word;
      end else if (cmd.finish) begin
         hold_v_in = 1'b0;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_word_index  = out_idx_ff;
   assign rsp_packed_word = out_word_ff;
   assign rsp_last        = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff    <= vchm_pkg::SIZE_X_RESET;
         size_y_ff    <= vchm_pkg::SIZE_Y_RESET;
         size_z_ff    <= vchm_pkg::SIZE_Z_RESET;
         air_ff       <= vchm_pkg::AIR_RESET;
         bsize_ff     <= vchm_pkg::BSIZE_RESET;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_z_ff     <= '0;
         zb_ff        <= '0;
         sw_x_ff      <= '0;
         cnt_ff       <= '0;
         bx_ff        <= '0;
         base_ff      <= '0;
         col_valid_ff <= '0;
         blk_valid_ff <= '0;
         h_pend_v_ff  <= 1'b0;
         b_pend_v_ff  <= 1'b0;
         h_cnt_ff     <= '0;
         b_cnt_ff     <= '0;
         hold_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         size_x_ff    <= size_x_in;
         size_y_ff    <= size_y_in;
         size_z_ff    <= size_z_in;
         air_ff       <= air_in;
         bsize_ff     <= bsize_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_z_ff     <= pos_z_in;
         zb_ff        <= zb_in;
         sw_x_ff      <= sw_x_in;
         cnt_ff       <= cnt_in;
         bx_ff        <= bx_in;
         base_ff      <= base_in;
         col_valid_ff <= col_valid_in;
         blk_valid_ff <= blk_valid_in;
         h_pend_v_ff  <= h_pend_v_in;
         b_pend_v_ff  <= b_pend_v_in;
         h_cnt_ff     <= h_cnt_in;
         b_cnt_ff     <= b_cnt_in;
         hold_v_ff    <= hold_v_in;
         out_v_ff     <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      h_pend_ff    <= h_pend_in;
      b_pend_ff    <= b_pend_in;
      hold_kind_ff <= hold_kind_in;
      hold_idx_ff  <= hold_idx_in;
      hold_word_ff <= hold_word_in;
      out_kind_ff  <= out_kind_in;
      out_idx_ff   <= out_idx_in;
      out_word_ff  <= out_word_in;
      out_last_ff  <= out_last_in;
   end

endmodule

`default_nettype wire

@@ sv/voxel_column_height_map.sv @@
// top level of the streaming voxel column height map with block max pooling
`default_nettype none

// Voxel type bytes stream in on req_ in x, then y, then z order, one beat per cycle while
// the block is collecting a slice. The beat that completes a z slice starts a sweep during
// which req_stall is high: each column is a registered read of the column store and block
// store, then a compare, update and pack step; at the end of a block row (or the chunk)
// the block store is read out the same way, with a flush of any pending half at chunk
// end and a closing step. Stalls on rsp_ stretch the sweep. Packed words leave through a
// hold stage and an output register, so the final beat of each burst carries rsp_last. No
// clearing pass is needed after reset or after a size register write; both stores are
// tracked by valid bits. Configuration writes are taken only while no sweep is running.

module voxel_column_height_map #(
   parameter int MAX_SIZE_X = 64,
   parameter int MAX_SIZE_Y = 4096,
   parameter int MAX_SIZE_Z = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [vchm_pkg::VOXEL_W-1:0]     req_voxel_type,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_kind,
   output logic [vchm_pkg::INDEX_W-1:0]          rsp_word_index,
   output logic [vchm_pkg::WORD_W-1:0]           rsp_packed_word,
   output logic                                  rsp_last,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [vchm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [vchm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   vchm_pkg::cmd_type    cmd;
   vchm_pkg::status_type status;
   logic                 csr_we;

   assign csr_we = csr_valid && csr_ready;

   vchm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   vchm_dp #(
      .MAX_SIZE_X (MAX_SIZE_X),
      .MAX_SIZE_Y (MAX_SIZE_Y),
      .MAX_SIZE_Z (MAX_SIZE_Z)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .voxel_type      (req_voxel_type),
      .cmd             (cmd),
      .status          (status),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_word_index  (rsp_word_index),
      .rsp_packed_word (rsp_packed_word),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

@@ tb/voxel_column_height_map_tb.sv @@
// self-checking testbench of the voxel column height map with block max pooling
module voxel_column_height_map_tb;

   localparam int MAX_X = 64;
   localparam int MAX_Y = 4096;
   localparam int MAX_Z = 64;
   localparam logic [vchm_pkg::CSR_INDEX_W-1:0] REG_SPARE = 3'd7;
   localparam int DRAIN_CYCLES = 300;
   localparam int PHASE_ITEMS = 34;

   typedef struct packed {
      vchm_pkg::kind_type                 kind;
      logic [vchm_pkg::INDEX_W-1:0]       index;
      logic [vchm_pkg::WORD_W-1:0]        word;
      logic                               last;
   } map_word_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [vchm_pkg::VOXEL_W-1:0]       req_voxel_type = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_kind;
   logic [vchm_pkg::INDEX_W-1:0]       rsp_word_index;
   logic [vchm_pkg::WORD_W-1:0]        rsp_packed_word;
   logic                               rsp_last;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [vchm_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [vchm_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   // predicted register file and map state
   logic [vchm_pkg::SIZE_X_W-1:0] cfg_size_x;
   logic [vchm_pkg::SIZE_Y_W-1:0] cfg_size_y;
   logic [vchm_pkg::SIZE_Z_W-1:0] cfg_size_z;
   logic [vchm_pkg::AIR_W-1:0]    cfg_air;
   logic [vchm_pkg::BSIZE_W-1:0]  cfg_block;
   logic [vchm_pkg::HEIGHT_W-1:0] col_height [MAX_X];
   logic [vchm_pkg::HEIGHT_W-1:0] blk_max [MAX_X];
   int unsigned                   at_x, at_y, at_z;
   logic                          half_valid [2];
   logic [vchm_pkg::HEIGHT_W-1:0] half_value [2];
   logic [vchm_pkg::INDEX_W-1:0]  word_count [2];

   map_word_type                 words_due[$];
   map_word_type                 burst[$];
   logic [vchm_pkg::VOXEL_W-1:0] voxel_backlog[$];
   int unsigned                  voxels_loaded = 0;
   int unsigned                  voxels_taken = 0;
   int unsigned                  error_count = 0;
   int unsigned                  send_idle_pct = 0;
   int unsigned                  stall_pct = 0;

   voxel_column_height_map dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_voxel_type  (req_voxel_type),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_word_index  (rsp_word_index),
      .rsp_packed_word (rsp_packed_word),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(int unsigned r, int unsigned top);
      if (r == 0) return 1;
      return (r > top) ? top : r;
   endfunction

   task automatic restart_map();
      for (int i = 0; i < MAX_X; i++) begin
         col_height[i] = '0;
         blk_max[i] = '0;
      end
      at_x = 0;
      at_y = 0;
      at_z = 0;
      for (int k = 0; k < 2; k++) begin
         half_valid[k] = 1'b0;
         half_value[k] = '0;
         word_count[k] = '0;
      end
   endtask

   task automatic apply_reg(logic [vchm_pkg::CSR_INDEX_W-1:0] idx,
                            logic [vchm_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         vchm_pkg::REG_SIZE_X: begin
            cfg_size_x = data[vchm_pkg::SIZE_X_W-1:0];
            restart_map();
         end
         vchm_pkg::REG_SIZE_Y: begin
            cfg_size_y = data[vchm_pkg::SIZE_Y_W-1:0];
            restart_map();
         end
         vchm_pkg::REG_SIZE_Z: begin
            cfg_size_z = data[vchm_pkg::SIZE_Z_W-1:0];
            restart_map();
         end
         vchm_pkg::REG_AIR_CODE: cfg_air = data[vchm_pkg::AIR_W-1:0];
         vchm_pkg::REG_BLOCK_SIZE: begin
            cfg_block = data[vchm_pkg::BSIZE_W-1:0];
            restart_map();
         end
         default: ;
      endcase
   endtask

   task automatic pack_half(vchm_pkg::kind_type k, logic [vchm_pkg::HEIGHT_W-1:0] h);
      if (half_valid[k]) begin
         burst.push_back('{k, word_count[k], {3'b000, h, 3'b000, half_value[k]}, 1'b0});
         word_count[k]++;
         half_valid[k] = 1'b0;
      end else begin
         half_value[k] = h;
         half_valid[k] = 1'b1;
      end
   endtask

   task automatic flush_half(vchm_pkg::kind_type k);
      if (half_valid[k]) begin
         burst.push_back('{k, word_count[k], {19'd0, half_value[k]}, 1'b0});
         word_count[k]++;
         half_valid[k] = 1'b0;
      end
   endtask

   // advances the map by one voxel and queues the words it releases
   task automatic sweep_voxel(logic [vchm_pkg::VOXEL_W-1:0] v);
      int unsigned sx, sy, sz, b, blocks;
      bit          chunk_end;
      sx = clamp_dim(cfg_size_x, MAX_X);
      sy = clamp_dim(cfg_size_y, MAX_Y);
      sz = clamp_dim(cfg_size_z, MAX_Z);
      b = (cfg_block == 0) ? 1 : cfg_block;
      if (v != cfg_air) col_height[at_x] = vchm_pkg::HEIGHT_W'(at_y + 1);
      if (at_x + 1 < sx) begin
         at_x++;
         return;
      end
      at_x = 0;
      if (at_y + 1 < sy) begin
         at_y++;
         return;
      end
      at_y = 0;
      burst.delete();
      for (int x = 0; x < sx; x++) begin
         pack_half(vchm_pkg::KIND_HEIGHT, col_height[x]);
         if (col_height[x] > blk_max[x / b]) blk_max[x / b] = col_height[x];
         col_height[x] = '0;
      end
      chunk_end = (at_z + 1 >= sz);
      if (chunk_end) flush_half(vchm_pkg::KIND_HEIGHT);
      if (chunk_end || (at_z + 1) % b == 0) begin
         blocks = (sx + b - 1) / b;
         for (int i = 0; i < blocks; i++) begin
            pack_half(vchm_pkg::KIND_BLOCK, blk_max[i]);
            blk_max[i] = '0;
         end
         if (chunk_end) flush_half(vchm_pkg::KIND_BLOCK);
      end
      if (chunk_end) begin
         at_z = 0;
         word_count[vchm_pkg::KIND_HEIGHT] = '0;
         word_count[vchm_pkg::KIND_BLOCK] = '0;
      end else begin
         at_z++;
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) words_due.push_back(burst[i]);
   endtask

   task automatic flag_mismatch(string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            sweep_voxel(req_voxel_type);
            voxels_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (voxel_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_voxel_type <= voxel_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch
      map_word_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (words_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat kind %0d index %0d word %h last %0d",
                  rsp_kind, rsp_word_index, rsp_packed_word, rsp_last));
            end else begin
               due = words_due.pop_front();
               if (rsp_kind !== due.kind || rsp_word_index !== due.index ||
                   rsp_packed_word !== due.word || rsp_last !== due.last)
                  flag_mismatch($sformatf(
                     "got kind %0d index %0d word %h last %0d, want %0d %0d %h %0d",
                     rsp_kind, rsp_word_index, rsp_packed_word, rsp_last,
                     due.kind, due.index, due.word, due.last));
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic load_voxel(logic [vchm_pkg::VOXEL_W-1:0] v);
      voxel_backlog.push_back(v);
      voxels_loaded++;
   endtask

   function automatic logic [vchm_pkg::VOXEL_W-1:0] random_voxel(int unsigned air_pct);
      if ($urandom_range(99) < air_pct) return cfg_air;
      return vchm_pkg::VOXEL_W'($urandom_range(255));
   endfunction

   task automatic settle();
      while (!(voxels_taken == voxels_loaded && words_due.size() == 0)) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [vchm_pkg::CSR_INDEX_W-1:0] idx,
                            logic [vchm_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      apply_reg(idx, data);
   endtask

   task automatic configure(int unsigned sx, int unsigned sy, int unsigned sz,
                            int unsigned air, int unsigned b);
      write_reg(vchm_pkg::REG_SIZE_X, vchm_pkg::CSR_DATA_W'(sx));
      write_reg(vchm_pkg::REG_SIZE_Y, vchm_pkg::CSR_DATA_W'(sy));
      write_reg(vchm_pkg::REG_SIZE_Z, vchm_pkg::CSR_DATA_W'(sz));
      write_reg(vchm_pkg::REG_AIR_CODE, vchm_pkg::CSR_DATA_W'(air));
      write_reg(vchm_pkg::REG_BLOCK_SIZE, vchm_pkg::CSR_DATA_W'(b));
   endtask

   initial begin : stimulus
      int unsigned sx, sy, sz, b, air, chunk, count, phase_start, room;
      cfg_size_x = vchm_pkg::SIZE_X_RESET;
      cfg_size_y = vchm_pkg::SIZE_Y_RESET;
      cfg_size_z = vchm_pkg::SIZE_Z_RESET;
      cfg_air = vchm_pkg::AIR_RESET;
      cfg_block = vchm_pkg::BSIZE_RESET;
      restart_map();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero sizes act as one, air at the top code
      configure(0, 3, 0, 8'hFF, 0);
      load_voxel(8'h00);
      load_voxel(8'h80);
      load_voxel(8'hFF);
      settle();
      configure(3, 1, 2, 0, 2);
      load_voxel(8'hFF);
      load_voxel(8'h00);
      load_voxel(8'h01);
      load_voxel(8'h00);
      load_voxel(8'h00);
      load_voxel(8'h7E);
      settle();
      // block wider than the chunk, air change and spare write mid slice, then restart
      configure(5, 2, 3, 0, 127);
      repeat (4) load_voxel(random_voxel(30));
      settle();
      write_reg(vchm_pkg::REG_AIR_CODE, 13'h00FF);
      write_reg(REG_SPARE, 13'h1FFF);
      repeat (6) load_voxel(random_voxel(30));
      settle();
      write_reg(vchm_pkg::REG_SIZE_Z, 13'd1);
      repeat (10) load_voxel(random_voxel(50));
      settle();

      // widest slice with single-column blocks, longest burst of beats
      configure(127, 1, 1, 0, 1);
      repeat (MAX_X) load_voxel(random_voxel(40));
      settle();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 54; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 54; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         phase_start = voxels_loaded;
         while (voxels_loaded - phase_start < PHASE_ITEMS) begin
            settle();
            sx = ($urandom_range(9) == 0) ? $urandom_range(0, 9) : $urandom_range(1, 6);
            sy = $urandom_range(0, 4);
            sz = $urandom_range(0, 4);
            b = ($urandom_range(7) == 0) ? 127 : $urandom_range(0, 5);
            air = ($urandom_range(1) == 0) ? 0 : $urandom_range(255);
            configure(sx, sy, sz, air, b);
            chunk = clamp_dim(sx, MAX_X) * clamp_dim(sy, MAX_Y) * clamp_dim(sz, MAX_Z);
            if ($urandom_range(9) < 2) count = $urandom_range(1, chunk);
            else count = chunk * $urandom_range(1, 2);
            room = PHASE_ITEMS - (voxels_loaded - phase_start);
            if (count > room) count = room;
            repeat (count) load_voxel(random_voxel(45));
         end
      end

      settle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #(12 * 2_000_000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ sim.f @@
sv/vchm_pkg.sv
sv/vchm_ram.sv
sv/vchm_ctrl.sv
sv/vchm_dp.sv
sv/voxel_column_height_map.sv
tb/voxel_column_height_map_tb.sv
